>>> sv/mowm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_pkg
// Shared types and constants for the max-of-window-minimums block.
// ----------------------------------------------------------------------------
package mowm_pkg;
	localparam int MAX_LEN_DEF = 64;
	localparam int VAL_W = 31;
	localparam int SIZE_W = 7;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] window_size;
		logic [VAL_W-1:0] best_minimum;
		logic last_result;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_FETCH, ST_LEFT, ST_RIGHT, ST_UPD, ST_SUFFIX, ST_EMIT
	} back_state_t;
endpackage
`default_nettype wire

>>> sv/mowm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mowm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/mowm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_front
// Accepts elements, writes them to the store, and queues closed batch lengths.
// ----------------------------------------------------------------------------
module mowm_front
	import mowm_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire in_item_t                   in_data,
	output logic                            st_we,
	output logic [$clog2(MAX_LEN+1)-1:0]    st_waddr,
	output logic [VAL_W-1:0]                st_wdata,
	// one-entry batch queue toward the back end
	output logic                            bq_valid,
	output logic [$clog2(MAX_LEN+1)-1:0]    bq_len,
	input  wire logic                       bq_pop
);
	localparam int CW = $clog2(MAX_LEN+1);
	logic [CW-1:0] count_q;
	logic          bq_valid_q;
	logic [CW-1:0] bq_len_q;
	logic          acc, close;

	// store is shared with the back end, so hold input while a batch waits
	assign in_ready = !bq_valid_q;
	assign acc      = in_valid && in_ready;
	assign close    = in_data.last || (count_q == CW'(MAX_LEN-1));
	assign st_we    = acc;
	assign st_waddr = count_q;
	assign st_wdata = in_data.value;
	assign bq_valid = bq_valid_q;
	assign bq_len   = bq_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			bq_valid_q <= 1'b0;
		end else begin
			if (bq_pop) bq_valid_q <= 1'b0;
			if (acc) begin
				if (close) begin
					count_q    <= '0;
					bq_valid_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && close) bq_len_q <= count_q + 1'b1;
	end
endmodule
`default_nettype wire

>>> sv/mowm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mowm_back
// Table clear, span walk per element, best-per-size table update, suffix max, emission.
// ----------------------------------------------------------------------------
module mowm_back
	import mowm_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    bq_valid,
	input  wire logic [$clog2(MAX_LEN+1)-1:0] bq_len,
	output logic                         bq_pop,
	output logic [$clog2(MAX_LEN+1)-1:0] st_raddr,
	input  wire logic [VAL_W-1:0]        st_rdata,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output out_item_t                    out_data
);
	localparam int CW = $clog2(MAX_LEN+1);
	localparam int BD = MAX_LEN + 1;

	back_state_t   state_q, state_d;
	logic [CW-1:0] n_q, i_q, p_q, lo_q, cnt_q;
	logic [VAL_W-1:0] v_q, run_q;
	logic          wait_q; // read latency bubble
	logic [VAL_W-1:0] best_rd;
	logic          b_we;
	logic [CW-1:0] b_wa, b_ra;
	logic [VAL_W-1:0] b_wd;
	logic          ov_q;
	out_item_t     od_q;
	logic          slot_free;
	logic          emit_fire;
	logic [CW-1:0] span;

	mowm_ram #(.WIDTH(VAL_W), .DEPTH(BD)) u_best (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
		.raddr(b_ra), .rdata(best_rd)
	);

	assign slot_free = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign span      = p_q - lo_q; // p_q one past hi
	// result register loads once the table read has landed
	assign emit_fire = (state_q == ST_EMIT) && wait_q && slot_free;
	assign bq_pop    = emit_fire && (cnt_q == n_q);

	always_comb begin
		st_raddr = p_q;
		b_we = 1'b0; b_wa = cnt_q; b_wd = '0; b_ra = cnt_q;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				b_we = bq_valid; b_wa = cnt_q;
				if (bq_valid && cnt_q == CW'(MAX_LEN)) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				st_raddr = i_q;
				if (wait_q) state_d = ST_LEFT;
			end
			ST_LEFT: begin
				st_raddr = p_q - 1'b1;
				if (wait_q && (p_q == '0 || st_rdata < v_q)) state_d = ST_RIGHT;
			end
			ST_RIGHT: begin
				st_raddr = p_q;
				b_ra = span;
				if (wait_q && (p_q == n_q || st_rdata < v_q)) state_d = ST_UPD;
			end
			ST_UPD: begin
				b_ra = span;
				b_wa = span; b_wd = v_q;
				b_we = wait_q && (v_q > best_rd);
				if (wait_q) state_d = (i_q + 1'b1 == n_q) ? ST_SUFFIX : ST_FETCH;
			end
			ST_SUFFIX: begin
				b_ra = cnt_q;
				b_wa = cnt_q; b_wd = run_q;
				b_we = wait_q && (run_q > best_rd);
				if (wait_q && cnt_q == CW'(1)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				b_ra = cnt_q;
				if (bq_pop) state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			wait_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					wait_q <= 1'b0;
					if (bq_valid) cnt_q <= cnt_q + 1'b1;
					if (state_d == ST_FETCH) begin
						n_q <= bq_len; i_q <= '0;
					end
				end
				ST_FETCH: begin
					wait_q <= !wait_q;
					if (wait_q) begin
						v_q <= st_rdata; lo_q <= i_q; p_q <= i_q;
					end
				end
				ST_LEFT: begin
					// probe p_q-1 each round; p_q holds current lo
					wait_q <= !wait_q;
					if (wait_q) begin
						if (state_d == ST_RIGHT) begin
							lo_q <= p_q; p_q <= i_q + 1'b1;
						end else begin
							p_q <= p_q - 1'b1;
						end
					end
				end
				ST_RIGHT: begin
					wait_q <= !wait_q || (state_d == ST_UPD);
					if (wait_q && state_d != ST_UPD) p_q <= p_q + 1'b1;
				end
				ST_UPD: begin
					wait_q <= !wait_q;
					if (wait_q) begin
						i_q <= i_q + 1'b1;
						if (state_d == ST_SUFFIX) begin
							cnt_q <= n_q; run_q <= '0;
						end
					end
				end
				ST_SUFFIX: begin
					wait_q <= !wait_q;
					if (wait_q) begin
						if (best_rd > run_q) run_q <= best_rd;
						if (state_d == ST_EMIT) cnt_q <= CW'(1);
						else cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_EMIT: begin
					wait_q <= !wait_q || !slot_free;
					if (emit_fire) begin
						od_q.window_size  <= SIZE_W'(cnt_q);
						od_q.best_minimum <= best_rd;
						od_q.last_result  <= (cnt_q == n_q);
						cnt_q  <= (cnt_q == n_q) ? '0 : cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/max_of_window_minimums.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_of_window_minimums
// Max over windows of the window minimum, for each window size 1..n.
// ----------------------------------------------------------------------------
// channel | dir | payload    | handshake
// in      | in  | in_item_t  | in_valid / in_ready
// out     | out | out_item_t | out_valid / out_ready
//
// Loading accepts elements while no closed batch waits. Closing a batch
// (last, or store full) starts the back end: a clear of all MAX_LEN+1
// best-per-size table entries, then per element a fetch, left/right probes
// (span+1 probes) and an update; then a suffix-max pass and one result per size.
// The span walk on the single store read port dominates, O(n) reads per
// element. Reset clears counters and state; input stalls while a closed
// batch is being processed, output stalls hold the result register.
// ----------------------------------------------------------------------------
module max_of_window_minimums
	import mowm_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	localparam int CW = $clog2(MAX_LEN+1);

	logic          st_we;
	logic [CW-1:0] st_waddr, st_raddr, bq_len;
	logic [VAL_W-1:0] st_wdata, st_rdata;
	logic          bq_valid, bq_pop;

	mowm_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .st_we(st_we), .st_waddr(st_waddr),
		.st_wdata(st_wdata), .bq_valid(bq_valid), .bq_len(bq_len),
		.bq_pop(bq_pop)
	);

	// element store, one extra slot so a one-past-end address stays in range
	mowm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN+1)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	mowm_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk(clk), .arst_n(arst_n), .bq_valid(bq_valid), .bq_len(bq_len),
		.bq_pop(bq_pop), .st_raddr(st_raddr), .st_rdata(st_rdata),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives batches of values into max_of_window_minimums and checks, for each
// closed batch, the best window minimum reported for every window size.
// ----------------------------------------------------------------------------

// Holds the expected per-size results and compares them with the block output.
class window_min_scoreboard;
	bit [30:0] batch_values[$];
	mowm_pkg::out_item_t pending_results[$];
	int error_count;

	// Called once for each accepted input transaction.
	function void note_input(mowm_pkg::in_item_t item);
		int n;
		int lo;
		int hi;
		int span;
		bit [30:0] best[0:64];
		mowm_pkg::out_item_t res;
		batch_values = {batch_values, item.value};
		if (!item.last && batch_values.size() < 64)
			return;
		n = batch_values.size();
		for (int k = 0; k <= 64; k++)
			best[k] = '0;
		for (int i = 0; i < n; i++) begin
			lo = i;
			hi = i;
			// Neighbours equal to the element are counted as part of its span.
			while (lo > 0 && batch_values[lo-1] >= batch_values[i])
				lo--;
			while (hi + 1 < n && batch_values[hi+1] >= batch_values[i])
				hi++;
			span = hi - lo + 1;
			if (batch_values[i] > best[span])
				best[span] = batch_values[i];
		end
		// Suffix maximum over span length.
		for (int k = n; k > 1; k--)
			if (best[k] > best[k-1])
				best[k-1] = best[k];
		for (int k = 1; k <= n; k++) begin
			res.window_size = 7'(k);
			res.best_minimum = best[k];
			res.last_result = (k == n);
			pending_results = {pending_results, res};
		end
		batch_values.delete();
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	// Called once for each accepted output transaction.
	task check_result(mowm_pkg::out_item_t got);
		mowm_pkg::out_item_t exp_res;
		if (pending_results.size() == 0) begin
			report($sformatf("unexpected result size=%0d", got.window_size));
			return;
		end
		exp_res = pending_results.pop_front();
		if (got.window_size !== exp_res.window_size)
			report($sformatf("window_size got %0d exp %0d",
				got.window_size, exp_res.window_size));
		if (got.best_minimum !== exp_res.best_minimum)
			report($sformatf("k=%0d best_minimum got %0d exp %0d",
				exp_res.window_size, got.best_minimum, exp_res.best_minimum));
		if (got.last_result !== exp_res.last_result)
			report($sformatf("k=%0d last_result got %0b exp %0b",
				exp_res.window_size, got.last_result, exp_res.last_result));
	endtask
endclass

module testbench;
	import mowm_pkg::*;

	localparam int CYCLE_LIMIT = 900000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	window_min_scoreboard scoreboard;
	int cycle_count;
	// Some stretches run with no idling on either side.
	bit busy_stretch;

	max_of_window_minimums dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Output side: check on every accepted output transaction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			scoreboard.check_result(out_data);
	end

	// Ready toggling on the output side, redrawn after each accepted transaction.
	initial begin
		int wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= 1'b1;
			// Hold ready until a transaction goes through.
			do @(posedge clk); while (!(out_valid && out_ready));
			wait_cycles = busy_stretch ? 0 : $urandom_range(0, 17);
			if (wait_cycles != 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (wait_cycles - 1) @(negedge clk);
			end
		end
	end

	// Send one input transaction after a random gap.
	task automatic send_item(input bit [30:0] value, input bit last);
		int gap;
		gap = busy_stretch ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{value: value, last: last};
		do @(posedge clk); while (!in_ready);
		scoreboard.note_input('{value: value, last: last});
		@(negedge clk);
	endtask

	function automatic bit [30:0] random_value(input int mode);
		case (mode)
			0: return 31'($urandom_range(0, 7));
			1: return 31'($urandom_range(0, 100));
			2: return 31'($urandom >> 1);
			default: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h7FFF_FFF0;
		endcase
	endfunction

	// One batch of len values; flag_last is off for a batch closed by the full store.
	task automatic send_batch(input int len, input int mode, input bit flag_last);
		for (int i = 0; i < len; i++)
			send_item(random_value(mode), flag_last && (i == len - 1));
	endtask

	initial begin
		int sent;
		int len;
		scoreboard = new();
		cycle_count = 0;
		busy_stretch = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: single elements at the value extremes.
		send_item(31'd0, 1'b1);
		send_item(31'h7FFF_FFFF, 1'b1);
		// Equal values: every span covers the whole batch.
		send_item(31'd5, 1'b0);
		send_item(31'd5, 1'b0);
		send_item(31'd5, 1'b1);
		// Rising, valley and zigzag shapes.
		send_item(31'd1, 1'b0);
		send_item(31'd2, 1'b0);
		send_item(31'd3, 1'b1);
		send_item(31'h7FFF_FFFF, 1'b0);
		send_item(31'd0, 1'b0);
		send_item(31'h7FFF_FFFF, 1'b1);
		send_item(31'h2AAA_AAAA, 1'b0);
		send_item(31'h5555_5555, 1'b0);
		send_item(31'd9, 1'b0);
		send_item(31'h5555_5555, 1'b1);
		// Full store closes the batch with no last flag.
		send_batch(64, 2, 1'b0);
		sent = 79;

		// Random batches, mostly short, with busy stretches mixed in.
		while (sent < 330) begin
			busy_stretch = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				len = 64;
			else
				len = $urandom_range(1, 12);
			send_batch(len, $urandom_range(0, 3), $urandom_range(0, 5) != 0 || len < 64);
			sent += len;
		end
		busy_stretch = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (scoreboard.pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (scoreboard.error_count == 0 && scoreboard.pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> max_of_window_minimums.f
sv/mowm_pkg.sv
sv/mowm_ram.sv
sv/mowm_front.sv
sv/mowm_back.sv
sv/max_of_window_minimums.sv
dv/testbench.sv
